/* design/biquad_iir_filter_assert.svh */
// assertion macros for the biquad filter
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

`ifndef SYNTH
`define BQF_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bqf assertion failed");
`define BQF_ASSERT(label, prop) `BQF_ASSERT_CLK(label, clock, reset, prop)
`else
`define BQF_ASSERT_CLK(label, clk, rst, prop)
`define BQF_ASSERT(label, prop)
`endif

`endif

/* design/bqf_pkg.sv */
`default_nettype none

package bqf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS       = 18;
   localparam int DELAY_BITS      = 24;
   localparam int FRAC_BITS       = 15;
   localparam int PROD_BITS       = COEF_BITS + DELAY_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int NUM_COEFS       = 5;

   localparam logic signed [COEF_BITS-1:0] GAIN_A0_RESET = COEF_BITS'(32768);

   // register indexes, also used to pick the coefficient operand
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      COEF_A0 = 3'd0,
      COEF_A1 = 3'd1,
      COEF_A2 = 3'd2,
      COEF_B1 = 3'd3,
      COEF_B2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      DATA_D1 = 2'd0,
      DATA_D2 = 2'd1,
      DATA_W  = 2'd2
   } data_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD      = 3'd0,
      ACC_LOAD_X    = 3'd1,
      ACC_LOAD_PROD = 3'd2,
      ACC_ADD       = 3'd3,
      ACC_SUB       = 3'd4
   } acc_op_type;

   typedef struct packed {
      acc_op_type   acc_op;
      coef_sel_type coef_sel;
      data_sel_type data_sel;
      logic         w_load;
      logic         finish;
   } mac_ctrl_type;

   typedef logic signed [NUM_COEFS-1:0][COEF_BITS-1:0] coef_bank_type;

endpackage

`default_nettype wire

/* design/bqf_req_if.sv */
`default_nettype none

interface bqf_req_if #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          block_end_in;

   modport source (output valid, output sample_in, output block_end_in, input ready);
   modport sink (input valid, input sample_in, input block_end_in, output ready);
endinterface

`default_nettype wire

/* design/bqf_rsp_if.sv */
`default_nettype none

interface bqf_rsp_if #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          block_end_out;

   modport source (output valid, output sample_out, output block_end_out, input ready);
   modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

/* design/bqf_mac.sv */
`default_nettype none

module bqf_mac #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                            clock,
   input  wire bqf_pkg::mac_ctrl_type                     ctrl,
   input  wire bqf_pkg::coef_bank_type                    coefs,
   input  wire logic signed [bqf_pkg::DELAY_BITS-1:0]     delay_one,
   input  wire logic signed [bqf_pkg::DELAY_BITS-1:0]     delay_two,
   input  wire logic signed [bqf_pkg::DELAY_BITS-1:0]     w_val,
   input  wire logic signed [SAMPLE_BITS-1:0]             x_val,
   output logic signed [bqf_pkg::DELAY_BITS-1:0]          w_sat,
   output logic signed [SAMPLE_BITS-1:0]                  y_sat
);
   localparam int PW    = bqf_pkg::PROD_BITS;
   localparam int FRAC  = bqf_pkg::FRAC_BITS;
   localparam int DW    = bqf_pkg::DELAY_BITS;
   localparam int CW    = bqf_pkg::COEF_BITS;
   localparam int XW    = SAMPLE_BITS + FRAC;
   localparam int ACC_W = ((XW > PW) ? XW : PW) + 3;
   localparam int RW    = ACC_W - FRAC;

   logic signed [CW-1:0]    coef_op;
   logic signed [DW-1:0]    data_op;
   logic signed [PW-1:0]    prod_in, prod_ff;
   logic signed [ACC_W-1:0] acc_in, acc_ff;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] rounded;
   logic signed [RW-1:0]    shifted;
   logic                    w_fits, y_fits;

   always_comb begin
      case (ctrl.coef_sel)
         bqf_pkg::COEF_A0: coef_op = coefs[bqf_pkg::COEF_A0];
         bqf_pkg::COEF_A1: coef_op = coefs[bqf_pkg::COEF_A1];
         bqf_pkg::COEF_A2: coef_op = coefs[bqf_pkg::COEF_A2];
         bqf_pkg::COEF_B1: coef_op = coefs[bqf_pkg::COEF_B1];
         bqf_pkg::COEF_B2: coef_op = coefs[bqf_pkg::COEF_B2];
         default:          coef_op = '0;
      endcase
      case (ctrl.data_sel)
         bqf_pkg::DATA_D1: data_op = delay_one;
         bqf_pkg::DATA_D2: data_op = delay_two;
         bqf_pkg::DATA_W:  data_op = w_val;
         default:          data_op = '0;
      endcase
   end

   assign prod_in  = PW'(coef_op) * PW'(data_op);
   assign prod_ext = {{(ACC_W-PW){prod_ff[PW-1]}}, prod_ff};

   always_comb begin
      case (ctrl.acc_op)
         bqf_pkg::ACC_LOAD_X:
            acc_in = {{(ACC_W-XW){x_val[SAMPLE_BITS-1]}}, x_val, {FRAC{1'b0}}};
         bqf_pkg::ACC_LOAD_PROD: acc_in = prod_ext;
         bqf_pkg::ACC_ADD:       acc_in = acc_ff + prod_ext;
         bqf_pkg::ACC_SUB:       acc_in = acc_ff - prod_ext;
         default:                acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then floor shift by taking the upper bits
   assign rounded = acc_ff + ACC_W'(1 << (FRAC - 1));
   assign shifted = rounded[ACC_W-1:FRAC];

   assign w_fits = (&shifted[RW-1:DW-1]) | ~(|shifted[RW-1:DW-1]);
   assign y_fits = (&shifted[RW-1:SAMPLE_BITS-1]) | ~(|shifted[RW-1:SAMPLE_BITS-1]);

   always_comb begin
      if (w_fits) begin
         w_sat = shifted[DW-1:0];
      end else begin
         w_sat = {shifted[RW-1], {(DW-1){~shifted[RW-1]}}};
      end
      if (y_fits) begin
         y_sat = shifted[SAMPLE_BITS-1:0];
      end else begin
         y_sat = {shifted[RW-1], {(SAMPLE_BITS-1){~shifted[RW-1]}}};
      end
   end
endmodule

`default_nettype wire

/* design/bqf_ctrl.sv */
`default_nettype none

module bqf_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire                    out_free,
   output bqf_pkg::mac_ctrl_type  ctrl,
   output logic                   idle
);
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_MUL_B1  = 10'b00_0000_0010,
      ST_MUL_B2  = 10'b00_0000_0100,
      ST_SUB_B2  = 10'b00_0000_1000,
      ST_ROUND_W = 10'b00_0001_0000,
      ST_MUL_A0  = 10'b00_0010_0000,
      ST_MUL_A1  = 10'b00_0100_0000,
      ST_MUL_A2  = 10'b00_1000_0000,
      ST_ADD_A2  = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      ctrl.acc_op   = bqf_pkg::ACC_HOLD;
      ctrl.coef_sel = bqf_pkg::COEF_A0;
      ctrl.data_sel = bqf_pkg::DATA_D1;
      ctrl.w_load   = 1'b0;
      ctrl.finish   = 1'b0;
      idle          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               ctrl.acc_op = bqf_pkg::ACC_LOAD_X;
               state_in    = ST_MUL_B1;
            end
         end
         ST_MUL_B1: begin
            ctrl.coef_sel = bqf_pkg::COEF_B1;
            ctrl.data_sel = bqf_pkg::DATA_D1;
            state_in      = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            ctrl.coef_sel = bqf_pkg::COEF_B2;
            ctrl.data_sel = bqf_pkg::DATA_D2;
            ctrl.acc_op   = bqf_pkg::ACC_SUB;
            state_in      = ST_SUB_B2;
         end
         ST_SUB_B2: begin
            ctrl.acc_op = bqf_pkg::ACC_SUB;
            state_in    = ST_ROUND_W;
         end
         ST_ROUND_W: begin
            ctrl.w_load = 1'b1;
            state_in    = ST_MUL_A0;
         end
         ST_MUL_A0: begin
            ctrl.coef_sel = bqf_pkg::COEF_A0;
            ctrl.data_sel = bqf_pkg::DATA_W;
            state_in      = ST_MUL_A1;
         end
         ST_MUL_A1: begin
            ctrl.coef_sel = bqf_pkg::COEF_A1;
            ctrl.data_sel = bqf_pkg::DATA_D1;
            ctrl.acc_op   = bqf_pkg::ACC_LOAD_PROD;
            state_in      = ST_MUL_A2;
         end
         ST_MUL_A2: begin
            ctrl.coef_sel = bqf_pkg::COEF_A2;
            ctrl.data_sel = bqf_pkg::DATA_D2;
            ctrl.acc_op   = bqf_pkg::ACC_ADD;
            state_in      = ST_ADD_A2;
         end
         ST_ADD_A2: begin
            ctrl.acc_op = bqf_pkg::ACC_ADD;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the previous response is still held
            if (out_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

`default_nettype wire

/* design/biquad_iir_filter.sv */
// Direct form II biquad on signed samples. A request is taken only while the
// filter is idle, so the next sample is accepted only after the sequencer has
// finished the last one. All five coefficient products (18 x 24 bits) run one
// after another through a single registered multiplier and accumulator. A
// finished response sits in an output register, so a new request is accepted
// while the response waits; the filter stalls only when the next response is
// ready before the old one left. Coefficients are signed Q3.15 and should be
// written only while the filter is idle; a write to an index above four is
// dropped. The delay line is not cleared at a block end; only reset clears it.
`default_nettype none

module biquad_iir_filter #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   bqf_req_if.sink                                  req_chan,
   bqf_rsp_if.source                                rsp_chan,
   input  wire                                      csr_wr_en,
   input  wire logic [bqf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bqf_pkg::COEF_BITS-1:0]       csr_wr_data
);
   `include "biquad_iir_filter_assert.svh"

   localparam int DW = bqf_pkg::DELAY_BITS;
   localparam bqf_pkg::coef_bank_type COEF_RESET =
      {{((bqf_pkg::NUM_COEFS-1)*bqf_pkg::COEF_BITS){1'b0}}, bqf_pkg::GAIN_A0_RESET};

   bqf_pkg::mac_ctrl_type  ctrl;
   bqf_pkg::coef_bank_type coef_ff, coef_in;
   logic                   idle;
   logic                   start;
   logic                   out_free;

   logic signed [DW-1:0]          delay_one_ff, delay_one_in;
   logic signed [DW-1:0]          delay_two_ff, delay_two_in;
   logic signed [DW-1:0]          w_ff, w_in;
   logic signed [DW-1:0]          w_sat;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          block_end_ff, block_end_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff, sample_out_in;
   logic                          block_end_out_ff, block_end_out_in;

   assign start    = req_chan.valid & idle;
   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   assign req_chan.ready         = idle;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_out    = sample_out_ff;
   assign rsp_chan.block_end_out = block_end_out_ff;

   bqf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ctrl     (ctrl),
      .idle     (idle)
   );

   bqf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .ctrl      (ctrl),
      .coefs     (coef_ff),
      .delay_one (delay_one_ff),
      .delay_two (delay_two_ff),
      .w_val     (w_ff),
      .x_val     (req_chan.sample_in),
      .w_sat     (w_sat),
      .y_sat     (y_sat)
   );

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bqf_pkg::COEF_A0: coef_in[bqf_pkg::COEF_A0] = csr_wr_data;
            bqf_pkg::COEF_A1: coef_in[bqf_pkg::COEF_A1] = csr_wr_data;
            bqf_pkg::COEF_A2: coef_in[bqf_pkg::COEF_A2] = csr_wr_data;
            bqf_pkg::COEF_B1: coef_in[bqf_pkg::COEF_B1] = csr_wr_data;
            bqf_pkg::COEF_B2: coef_in[bqf_pkg::COEF_B2] = csr_wr_data;
            default: begin
               coef_in = coef_ff;
            end
         endcase
      end
   end

   always_comb begin
      w_in             = ctrl.w_load ? w_sat : w_ff;
      block_end_in     = start ? req_chan.block_end_in : block_end_ff;
      delay_one_in     = ctrl.finish ? w_ff : delay_one_ff;
      delay_two_in     = ctrl.finish ? delay_one_ff : delay_two_ff;
      sample_out_in    = ctrl.finish ? y_sat : sample_out_ff;
      block_end_out_in = ctrl.finish ? block_end_ff : block_end_out_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff             <= w_in;
      block_end_ff     <= block_end_in;
      sample_out_ff    <= sample_out_in;
      block_end_out_ff <= block_end_out_in;
   end

   // one request in flight at a time
   `BQF_ASSERT(a_busy_after_accept, (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
   // a response only appears when the sequencer finishes a sample
   `BQF_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(ctrl.finish))
   // the delay line moves only at the end of a sample
   `BQF_ASSERT(a_delay_hold, !ctrl.finish |=> $stable(delay_two_ff))
endmodule

`default_nettype wire
